### sv/mks_pkg.sv
// Shared types, constants and the Morse code table of the keyer segment generator.
package mks_pkg;

  localparam int unsigned DUR_W     = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PAT_W     = 5;
  localparam int unsigned LEN_W     = 3;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_DOT        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DASH       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_GAP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LETTER_GAP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PASS_GAP   = 3'd4;

  localparam logic [DUR_W-1:0] RST_DOT        = 16'd200;
  localparam logic [DUR_W-1:0] RST_DASH       = 16'd500;
  localparam logic [DUR_W-1:0] RST_SYMBOL_GAP = 16'd200;
  localparam logic [DUR_W-1:0] RST_LETTER_GAP = 16'd500;
  localparam logic [DUR_W-1:0] RST_PASS_GAP   = 16'd1000;

  typedef struct packed {
    logic [DUR_W-1:0] dot;
    logic [DUR_W-1:0] dash;
    logic [DUR_W-1:0] symbol_gap;
    logic [DUR_W-1:0] letter_gap;
    logic [DUR_W-1:0] pass_gap;
  } mks_dur_t;

  // Symbol i of a character sits in pat[i]; a 1 is a dash.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } mks_code_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_MORSE,
    CLS_SPACE,
    CLS_PASS
  } mks_cls_t;

  typedef struct packed {
    mks_cls_t  cls;
    mks_code_t code;
  } mks_dec_t;

  // Table index: 0..25 for A..Z, 26..35 for 0..9.
  function automatic mks_code_t mks_code_lookup(input logic [5:0] idx);
    mks_code_t c;
    case (idx)
      6'd0:  c = '{len: 3'd2, pat: 5'b00010};
      6'd1:  c = '{len: 3'd4, pat: 5'b00001};
      6'd2:  c = '{len: 3'd4, pat: 5'b00101};
      6'd3:  c = '{len: 3'd3, pat: 5'b00001};
      6'd4:  c = '{len: 3'd1, pat: 5'b00000};
      6'd5:  c = '{len: 3'd4, pat: 5'b00100};
      6'd6:  c = '{len: 3'd3, pat: 5'b00011};
      6'd7:  c = '{len: 3'd4, pat: 5'b00000};
      6'd8:  c = '{len: 3'd2, pat: 5'b00000};
      6'd9:  c = '{len: 3'd4, pat: 5'b01110};
      6'd10: c = '{len: 3'd3, pat: 5'b00101};
      6'd11: c = '{len: 3'd4, pat: 5'b00010};
      6'd12: c = '{len: 3'd2, pat: 5'b00011};
      6'd13: c = '{len: 3'd2, pat: 5'b00001};
      6'd14: c = '{len: 3'd3, pat: 5'b00111};
      6'd15: c = '{len: 3'd4, pat: 5'b00110};
      6'd16: c = '{len: 3'd4, pat: 5'b01011};
      6'd17: c = '{len: 3'd3, pat: 5'b00010};
      6'd18: c = '{len: 3'd3, pat: 5'b00000};
      6'd19: c = '{len: 3'd1, pat: 5'b00001};
      6'd20: c = '{len: 3'd3, pat: 5'b00100};
      6'd21: c = '{len: 3'd4, pat: 5'b01000};
      6'd22: c = '{len: 3'd3, pat: 5'b00110};
      6'd23: c = '{len: 3'd4, pat: 5'b01001};
      6'd24: c = '{len: 3'd4, pat: 5'b01101};
      6'd25: c = '{len: 3'd4, pat: 5'b00011};
      6'd26: c = '{len: 3'd5, pat: 5'b11111};
      6'd27: c = '{len: 3'd5, pat: 5'b11110};
      6'd28: c = '{len: 3'd5, pat: 5'b11100};
      6'd29: c = '{len: 3'd5, pat: 5'b11000};
      6'd30: c = '{len: 3'd5, pat: 5'b10000};
      6'd31: c = '{len: 3'd5, pat: 5'b00000};
      6'd32: c = '{len: 3'd5, pat: 5'b00001};
      6'd33: c = '{len: 3'd5, pat: 5'b00011};
      6'd34: c = '{len: 3'd5, pat: 5'b00111};
      6'd35: c = '{len: 3'd5, pat: 5'b01111};
      default: c = '{len: 3'd0, pat: 5'b00000};
    endcase
    return c;
  endfunction

endpackage

### sv/mks_if.sv
// Stream interfaces for text input, LED segment output and register writes.
interface mks_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

interface mks_out_if;
  logic                      valid;
  logic                      ready;
  logic                      led_level;
  logic [mks_pkg::DUR_W-1:0] duration_ms;
  logic                      last;
  modport source (output valid, led_level, duration_ms, last, input ready);
  modport sink   (input valid, led_level, duration_ms, last, output ready);
endinterface

interface mks_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mks_pkg::REG_IDX_W-1:0] index;
  logic [mks_pkg::DUR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/mks_regs.sv
// Timing register file written through the configuration channel.
module mks_regs (
  input  logic              clk,
  input  logic              rst,
  mks_cfg_if.sink           cfg,
  output mks_pkg::mks_dur_t dur
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur.dot        <= mks_pkg::RST_DOT;
      dur.dash       <= mks_pkg::RST_DASH;
      dur.symbol_gap <= mks_pkg::RST_SYMBOL_GAP;
      dur.letter_gap <= mks_pkg::RST_LETTER_GAP;
      dur.pass_gap   <= mks_pkg::RST_PASS_GAP;
    end else if (cfg.valid) begin
      case (cfg.index)
        mks_pkg::REG_DOT:        dur.dot        <= cfg.data;
        mks_pkg::REG_DASH:       dur.dash       <= cfg.data;
        mks_pkg::REG_SYMBOL_GAP: dur.symbol_gap <= cfg.data;
        mks_pkg::REG_LETTER_GAP: dur.letter_gap <= cfg.data;
        mks_pkg::REG_PASS_GAP:   dur.pass_gap   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### sv/mks_decode.sv
// Character classifier: folds case and looks up the Morse pattern.
module mks_decode (
  input  logic              kind,
  input  logic [7:0]        char_code,
  output mks_pkg::mks_dec_t dec
);

  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_UP_A   = 8'h41;
  localparam logic [7:0] ASCII_UP_Z   = 8'h5A;
  localparam logic [7:0] ASCII_LO_A   = 8'h61;
  localparam logic [7:0] ASCII_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] DIGIT_BASE   = 8'd26;

  logic [7:0] folded;
  logic [7:0] letter_idx;
  logic [7:0] digit_idx;

  always_comb begin
    folded = char_code;
    if (char_code >= ASCII_LO_A && char_code <= ASCII_LO_Z) begin
      folded = char_code - CASE_OFFSET;
    end
    letter_idx = folded - ASCII_UP_A;
    digit_idx  = folded - ASCII_ZERO + DIGIT_BASE;

    dec.cls  = mks_pkg::CLS_NONE;
    dec.code = '0;
    if (kind) begin
      dec.cls = mks_pkg::CLS_PASS;
    end else if (folded == ASCII_SPACE) begin
      dec.cls = mks_pkg::CLS_SPACE;
    end else if (folded >= ASCII_UP_A && folded <= ASCII_UP_Z) begin
      dec.cls  = mks_pkg::CLS_MORSE;
      dec.code = mks_pkg::mks_code_lookup(letter_idx[5:0]);
    end else if (folded >= ASCII_ZERO && folded <= ASCII_NINE) begin
      dec.cls  = mks_pkg::CLS_MORSE;
      dec.code = mks_pkg::mks_code_lookup(digit_idx[5:0]);
    end
  end

endmodule

### sv/mks_seq.sv
// Segment sequencer: steps a character's symbols; one segment a cycle unless stalled.
module mks_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mks_pkg::mks_dec_t dec,
  input  mks_pkg::mks_dur_t dur,
  mks_out_if.source         seg
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIGH,
    S_GAP,
    S_SPACE,
    S_LETTER,
    S_PASS
  } state_t;

  state_t                      state;
  logic [mks_pkg::PAT_W-1:0]   pat;
  logic [mks_pkg::LEN_W-1:0]   cnt;
  logic                        load;
  logic                        level_next;
  logic [mks_pkg::DUR_W-1:0]   dur_next;
  logic                        last_next;

  assign in_ready = (state == S_IDLE);
  // The output register takes a new segment when it is empty or being drained.
  assign load = !seg.valid || seg.ready;

  // One duration selector serves every segment kind.
  always_comb begin
    level_next = 1'b0;
    last_next  = 1'b0;
    dur_next   = '0;
    case (state)
      S_HIGH: begin
        level_next = 1'b1;
        dur_next   = pat[0] ? dur.dash : dur.dot;
      end
      S_GAP, S_SPACE: begin
        dur_next = dur.symbol_gap;
      end
      S_LETTER: begin
        dur_next  = dur.letter_gap;
        last_next = 1'b1;
      end
      S_PASS: begin
        dur_next  = dur.pass_gap;
        last_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      seg.valid       <= 1'b0;
      seg.led_level   <= 1'b0;
      seg.duration_ms <= '0;
      seg.last        <= 1'b0;
    end else begin
      if (state != S_IDLE && load) begin
        seg.valid       <= 1'b1;
        seg.led_level   <= level_next;
        seg.duration_ms <= dur_next;
        seg.last        <= last_next;
      end else if (seg.valid && seg.ready) begin
        seg.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (dec.cls)
              mks_pkg::CLS_MORSE: begin
                pat   <= dec.code.pat;
                cnt   <= dec.code.len;
                state <= S_HIGH;
              end
              mks_pkg::CLS_SPACE: state <= S_SPACE;
              mks_pkg::CLS_PASS:  state <= S_PASS;
              default: ;
            endcase
          end
        end
        S_HIGH: begin
          if (load) begin
            state <= S_GAP;
          end
        end
        S_GAP: begin
          if (load) begin
            pat   <= pat >> 1;
            cnt   <= cnt - 3'd1;
            state <= (cnt == 3'd1) ? S_LETTER : S_HIGH;
          end
        end
        S_SPACE: begin
          if (load) begin
            state <= S_LETTER;
          end
        end
        S_LETTER, S_PASS: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/morse_keyer_segments.sv
// Top level of the Morse keyer segment generator.
// Each text transfer is a character or an end-of-pass marker; the block answers with a run
// of LED segments (level, duration in ms, last flag) on the seg channel, one segment per
// cycle unless seg stalls, from a single sequencer and duration selector. A character of n
// Morse symbols gives 2n + 1 segments, so at most 11 for a five-symbol digit; a space
// gives 2, an end-of-pass marker 1, and an unknown character none. The text channel is
// not ready while a character is being expanded. The user must write the timing registers
// on cfg only while idle; the block itself does not enforce it.
module morse_keyer_segments (
  input  logic      clk,
  input  logic      rst,
  mks_in_if.sink    text,
  mks_out_if.source seg,
  mks_cfg_if.sink   cfg
);

  mks_pkg::mks_dur_t dur;
  mks_pkg::mks_dec_t dec;
  logic              in_ready;

  assign text.ready = in_ready;

  mks_regs u_regs (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .dur (dur)
  );

  mks_decode u_decode (
    .kind      (text.kind),
    .char_code (text.char_code),
    .dec       (dec)
  );

  mks_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (in_ready),
    .dec      (dec),
    .dur      (dur),
    .seg      (seg)
  );

endmodule

### sv/mks_checker.sv
// Port-level checks of the keyer segment generator and their bind to the top level.
module mks_checker (
  input logic       clk,
  input logic       rst,
  mks_in_if.sink    text,
  mks_out_if.source seg,
  mks_cfg_if.sink   cfg
);

  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // An end-of-pass marker always produces a segment, so the block must go busy.
  a_pass_busy: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && text.kind |=> !text.ready)
    else $error("text ready right after an end-of-pass transfer");

  a_space_busy: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && !text.kind && text.char_code == ASCII_SPACE
    |=> !text.ready)
    else $error("text ready right after a space transfer");

  // Every item closes with a LOW gap, so an ON segment never carries last.
  a_high_not_last: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.led_level |-> !seg.last)
    else $error("ON segment flagged as last");

  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg.valid && !seg.ready |=> seg.valid && $stable(seg.led_level)
      && $stable(seg.duration_ms) && $stable(seg.last))
    else $error("stalled segment changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |-> cfg.ready)
    else $error("configuration write stalled");

endmodule

bind morse_keyer_segments mks_checker u_mks_checker (
  .clk  (clk),
  .rst  (rst),
  .text (text),
  .seg  (seg),
  .cfg  (cfg)
);

### bench/morse_keyer_segments_tb.sv
// Self-checking testbench for the Morse keyer segment generator, with a built-in segment predictor.
module morse_keyer_segments_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DUR_W     = mks_pkg::DUR_W;
  localparam int unsigned REG_IDX_W = mks_pkg::REG_IDX_W;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } text_item_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
    logic             last;
  } segment_t;

  logic clk = 1'b0;
  logic rst;

  mks_in_if  text_bus();
  mks_out_if seg_bus();
  mks_cfg_if cfg_bus();

  morse_keyer_segments i_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_bus),
    .seg  (seg_bus),
    .cfg  (cfg_bus)
  );

  always #6 clk = ~clk;

  // Symbols of A..Z then 0..9.
  string morse_patterns [0:35] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  logic [DUR_W-1:0] dot_dur        = mks_pkg::RST_DOT;
  logic [DUR_W-1:0] dash_dur       = mks_pkg::RST_DASH;
  logic [DUR_W-1:0] symbol_gap_dur = mks_pkg::RST_SYMBOL_GAP;
  logic [DUR_W-1:0] letter_gap_dur = mks_pkg::RST_LETTER_GAP;
  logic [DUR_W-1:0] pass_gap_dur   = mks_pkg::RST_PASS_GAP;

  text_item_t pending_text [$];
  segment_t   pending_segments [$];
  logic       text_taken;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 70;
  int         mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic expand_to_segments(input logic kind, input logic [7:0] code);
    logic [7:0] c;
    int         idx;
    string      pat;
    c = code;
    if (kind) begin
      pending_segments.push_back('{1'b0, pass_gap_dur, 1'b1});
      return;
    end
    if (c >= "a" && c <= "z") c = c - 8'h20;
    if (c == " ") begin
      pending_segments.push_back('{1'b0, symbol_gap_dur, 1'b0});
    end else begin
      if (c >= "A" && c <= "Z") idx = int'(c) - int'("A");
      else if (c >= "0" && c <= "9") idx = 26 + int'(c) - int'("0");
      else return;
      pat = morse_patterns[idx];
      for (int i = 0; i < pat.len(); i++) begin
        pending_segments.push_back('{1'b1, (pat[i] == "-") ? dash_dur : dot_dur, 1'b0});
        pending_segments.push_back('{1'b0, symbol_gap_dur, 1'b0});
      end
    end
    pending_segments.push_back('{1'b0, letter_gap_dur, 1'b1});
  endtask

  // Text driver and segment sink readiness, both changed on the falling edge.
  always @(negedge clk) begin
    text_item_t next_item;
    if (rst) begin
      text_bus.valid <= 1'b0;
      seg_bus.ready  <= 1'b0;
    end else begin
      seg_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!text_bus.valid || text_taken) begin
        if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_text.pop_front();
          text_bus.valid     <= 1'b1;
          text_bus.kind      <= next_item.kind;
          text_bus.char_code <= next_item.code;
        end else begin
          text_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each text transfer and checks each segment transfer.
  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst) begin
      text_taken <= 1'b0;
    end else begin
      text_taken <= text_bus.valid && text_bus.ready;
      if (text_bus.valid && text_bus.ready)
        expand_to_segments(text_bus.kind, text_bus.char_code);
      if (seg_bus.valid && seg_bus.ready) begin
        got = '{seg_bus.led_level, seg_bus.duration_ms, seg_bus.last};
        if (pending_segments.size() == 0) begin
          report_mismatch($sformatf("segment %0b/%0d/%0b with nothing expected",
                                    got.level, got.dur, got.last));
        end else begin
          want = pending_segments.pop_front();
          if (got.level !== want.level)
            report_mismatch($sformatf("led_level %0b, expected %0b", got.level, want.level));
          if (got.dur !== want.dur)
            report_mismatch($sformatf("duration_ms %0d, expected %0d", got.dur, want.dur));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        end
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      mks_pkg::REG_DOT:        dot_dur        = value;
      mks_pkg::REG_DASH:       dash_dur       = value;
      mks_pkg::REG_SYMBOL_GAP: symbol_gap_dur = value;
      mks_pkg::REG_LETTER_GAP: letter_gap_dur = value;
      mks_pkg::REG_PASS_GAP:   pass_gap_dur   = value;
      default: ;
    endcase
  endtask

  // Writes all timing registers back to back, then one index that maps to nothing.
  task automatic set_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                            input logic [DUR_W-1:0] sym_gap, input logic [DUR_W-1:0] let_gap,
                            input logic [DUR_W-1:0] pass_gap);
    write_reg(mks_pkg::REG_DOT, dot);
    write_reg(mks_pkg::REG_DASH, dash);
    write_reg(mks_pkg::REG_SYMBOL_GAP, sym_gap);
    write_reg(mks_pkg::REG_LETTER_GAP, let_gap);
    write_reg(mks_pkg::REG_PASS_GAP, pass_gap);
    write_reg(mks_pkg::REG_PASS_GAP + REG_IDX_W'($urandom_range(1, 3)), DUR_W'($urandom));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Returns once every item has been sent and every segment has arrived, then lets
  // an unknown character still in flight finish. The queues are looked at on the
  // rising edge, after the driver's falling-edge updates have settled.
  task automatic wait_drained();
    while (pending_text.size() != 0 || text_bus.valid || pending_segments.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Mostly readable text in mixed case with spaces and pass markers, plus random bytes.
  task automatic send_random_text(input int count);
    text_item_t it;
    int         pick;
    int         sym;
    int         counted;
    counted = 0;
    while (counted < count) begin
      pick = $urandom_range(99);
      it.kind = 1'b0;
      it.code = 8'h00;
      if (pick < 70) begin
        sym = $urandom_range(35);
        if (sym < 26) begin
          it.code = 8'(int'("A") + sym);
          // Bit 5 turns an upper-case letter into lower case.
          if ($urandom_range(1)) it.code = it.code | 8'h20;
        end else begin
          it.code = 8'(int'("0") + sym - 26);
        end
      end else if (pick < 80) begin
        it.code = " ";
      end else if (pick < 88) begin
        it.kind = 1'b1;
        it.code = 8'($urandom_range(255));
      end else begin
        it.code = 8'($urandom_range(255));
      end
      pending_text.push_back(it);
      if (it.kind || it.code == " " || (it.code >= "A" && it.code <= "Z") ||
          (it.code >= "a" && it.code <= "z") || (it.code >= "0" && it.code <= "9"))
        counted++;
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0] directed [19] = '{
      "A", "a", "Z", "z", "0", "9", " ", "E", "T", "@", "[", 8'h60, "{", "/", ":",
      8'h00, 8'hFF, 8'h80, 8'h7F
    };
    rst = 1'b1;
    text_bus.valid     = 1'b0;
    text_bus.kind      = 1'b0;
    text_bus.char_code = 8'h00;
    seg_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed characters at the reset timing; the pass markers carry junk in char_code.
    foreach (directed[i]) pending_text.push_back('{1'b0, directed[i]});
    pending_text.push_back('{1'b1, 8'h00});
    pending_text.push_back('{1'b1, 8'hFF});
    wait_drained();

    set_timing(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_random_text(52);
    set_timing(DUR_W'($urandom_range(1, 65535)), DUR_W'($urandom_range(1, 65535)),
               DUR_W'($urandom_range(1, 65535)), DUR_W'($urandom_range(1, 65535)),
               DUR_W'($urandom_range(1, 65535)));
    send_random_text(52);

    send_idle_pct = 70;
    recv_idle_pct = 18;
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random_text(52);
    // A zero in a register is passed straight through to the segments it times.
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random_text(52);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timing(DUR_W'($urandom_range(1, 65535)), DUR_W'($urandom_range(1, 65535)),
               DUR_W'($urandom_range(1, 65535)), DUR_W'($urandom_range(1, 65535)),
               DUR_W'($urandom_range(1, 65535)));
    send_random_text(52);
    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_random_text(52);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
